/* sv/lfu_pkg.sv */
`timescale 1ns / 1ps

package lfu_pkg;

  // fixed field widths of the stream and configuration ports
  localparam int IN_PAGE_W     = 16;
  localparam int IN_TDATA_W    = 16;
  localparam int FRAME_IDX_W   = 3;
  localparam int EVICT_PAGE_W  = 16;
  localparam int FAULT_TOTAL_W = 32;
  localparam int OUT_FIELDS_W  = 1 + FRAME_IDX_W + 1 + EVICT_PAGE_W + FAULT_TOTAL_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int CFG_W         = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // kind of update broadcast to the frame cells
  typedef enum logic {
    WR_INC,
    WR_LOAD
  } wr_kind_e;

endpackage

/* sv/lfu_page_replacement.sv */
`timescale 1ns / 1ps

// lfu page replacement engine
// s_axis carries one page reference per beat (tdata = page, 16 bits);
// m_axis returns one result beat per reference: fault flag, frame now
// holding the page, eviction flag and evicted page, saturating fault total.
// cfg_we_i / cfg_wdata_i write frames_in_use (0 acts as 1, values above
// NUM_FRAMES act as NUM_FRAMES); write it only while the engine is idle.
// each reference is handled in steps: the beat is latched into the seed
// register, the search record walks the chain of frame cells one cell per
// cycle (hit, first free frame and least-used victim), then the chosen
// cell is updated and the output register loaded once it can take the
// result. one reference is in flight at a time.
// the result sits in an output register, so s_axis_tready comes back as
// soon as the result is loaded even if m_axis_tready is low; a stalled
// receiver holds the next result in the engine until the register frees.
// reset empties all frames, clears the fault total and sets
// frames_in_use to 8; frame pages and counts are not cleared

module lfu_page_replacement import lfu_pkg::*; #(
  parameter int NUM_FRAMES = 8,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration: frames_in_use
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  // page references, tdata[15:0] = page
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // results, tdata from bit 0: fault, frame_index[2:0], evicted_valid,
  // evicted_page[15:0], fault_total[31:0], zero fill
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int IdxW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int NcntW = $clog2(NUM_FRAMES + 1);
  localparam int PadW  = OUT_TDATA_W - OUT_FIELDS_W;

  // engine states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // search record handed from cell to cell
  typedef struct packed {
    logic [PAGE_BITS-1:0]  page;
    logic                  hit;
    logic [IdxW-1:0]       hit_idx;
    logic                  free;
    logic [IdxW-1:0]       free_idx;
    logic [COUNT_BITS-1:0] min_cnt;
    logic [PAGE_BITS-1:0]  min_page;
    logic [IdxW-1:0]       min_idx;
  } rec_t;

  // update broadcast to all cells
  typedef struct packed {
    logic                 en;
    wr_kind_e             kind;
    logic [IdxW-1:0]      idx;
    logic [PAGE_BITS-1:0] page;
  } wr_t;

  logic [CFG_W-1:0]         cfg_q;
  logic [NcntW-1:0]         n_eff;
  logic [NUM_FRAMES-1:0]    active;

  logic [1:0]               state_q, state_d;
  logic [IdxW-1:0]          step_q, step_d;
  rec_t                     seed_q;
  rec_t                     chain [NUM_FRAMES+1];
  rec_t                     result;
  wr_t                      wr;

  logic                     s_beat;
  logic                     commit;
  logic                     evict;
  logic [FAULT_TOTAL_W-1:0] fault_total_q, fault_total_d;
  logic                     m_valid_q;
  logic [OUT_TDATA_W-1:0]   m_data_q, m_data_d;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // clamp the frame count into 1..NUM_FRAMES
  always_comb begin
    priority if (cfg_q == '0) begin
      n_eff = NcntW'(1);
    end else if (int'(cfg_q) > NUM_FRAMES) begin
      n_eff = NcntW'(NUM_FRAMES);
    end else begin
      n_eff = NcntW'(cfg_q);
    end
    for (int i = 0; i < NUM_FRAMES; i++) begin
      active[i] = (i < int'(n_eff));
    end
  end

  // seed record for the chain
  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      seed_q <= '{page: PAGE_BITS'(s_axis_tdata[IN_PAGE_W-1:0]), default: '0};
    end
  end

  assign chain[0] = seed_q;

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    lfu_cell #(
      .NUM_FRAMES (NUM_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS),
      .IDX        (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .active_i (active[g]),
      .rec_i    (chain[g]),
      .rec_o    (chain[g+1]),
      .wr_i     (wr)
    );
  end

  assign result = chain[NUM_FRAMES];

  // sequencer: latch, walk the chain, commit
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_beat) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        if (step_q == IdxW'(NUM_FRAMES - 1)) begin
          state_d = ST_DONE;
        end else begin
          step_d = step_q + IdxW'(1);
        end
      end
      ST_DONE: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // commit once the output register can take the result
  assign commit = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
  assign evict  = !result.hit && !result.free;

  always_comb begin
    wr.en   = commit;
    wr.page = result.page;
    if (result.hit) begin
      wr.kind = WR_INC;
      wr.idx  = result.hit_idx;
    end else begin
      wr.kind = WR_LOAD;
      wr.idx  = result.free ? result.free_idx : result.min_idx;
    end
  end

  // saturating fault total
  always_comb begin
    fault_total_d = fault_total_q;
    if (!result.hit && (fault_total_q != '1)) begin
      fault_total_d = fault_total_q + FAULT_TOTAL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_total_q <= '0;
    end else if (commit) begin
      fault_total_q <= fault_total_d;
    end
  end

  // result beat
  always_comb begin
    m_data_d = {PadW'(0),
                fault_total_d,
                evict ? EVICT_PAGE_W'(result.min_page) : EVICT_PAGE_W'(0),
                evict,
                FRAME_IDX_W'(wr.idx),
                !result.hit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (commit) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      m_data_q <= m_data_d;
    end
  end

endmodule

/* sv/lfu_cell.sv */
`timescale 1ns / 1ps

module lfu_cell import lfu_pkg::*; #(
  parameter int NUM_FRAMES = 8,
  parameter int PAGE_BITS  = 16,
  parameter int COUNT_BITS = 16,
  parameter int IDX        = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic active_i,
  input  logic [((PAGE_BITS * 2) + COUNT_BITS + 2
                 + 3 * ((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)) - 1:0] rec_i,
  output logic [((PAGE_BITS * 2) + COUNT_BITS + 2
                 + 3 * ((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)) - 1:0] rec_o,
  input  logic [(PAGE_BITS + 2 + ((NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1)) - 1:0] wr_i
);

  localparam int IdxW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  typedef struct packed {
    logic [PAGE_BITS-1:0]  page;
    logic                  hit;
    logic [IdxW-1:0]       hit_idx;
    logic                  free;
    logic [IdxW-1:0]       free_idx;
    logic [COUNT_BITS-1:0] min_cnt;
    logic [PAGE_BITS-1:0]  min_page;
    logic [IdxW-1:0]       min_idx;
  } rec_t;

  typedef struct packed {
    logic                 en;
    wr_kind_e             kind;
    logic [IdxW-1:0]      idx;
    logic [PAGE_BITS-1:0] page;
  } wr_t;

  rec_t rec_in, rec_d, rec_q;
  wr_t  wr;

  logic                  valid_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic                  match;
  logic                  better;
  logic                  sel;

  assign rec_in = rec_t'(rec_i);
  assign wr     = wr_t'(wr_i);
  assign rec_o  = rec_q;
  assign sel    = wr.en && (wr.idx == IdxW'(IDX));

  assign match  = active_i && valid_q && (page_q == rec_in.page);
  assign better = (IDX == 0) || (cnt_q < rec_in.min_cnt) ||
                  ((cnt_q == rec_in.min_cnt) && (page_q < rec_in.min_page));

  // fold this frame into the running search record
  always_comb begin
    rec_d = rec_in;
    if (match && !rec_in.hit) begin
      rec_d.hit     = 1'b1;
      rec_d.hit_idx = IdxW'(IDX);
    end
    if (active_i && !valid_q && !rec_in.free) begin
      rec_d.free     = 1'b1;
      rec_d.free_idx = IdxW'(IDX);
    end
    if (active_i && better) begin
      rec_d.min_cnt  = cnt_q;
      rec_d.min_page = page_q;
      rec_d.min_idx  = IdxW'(IDX);
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sel && (wr.kind == WR_LOAD)) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sel) begin
      unique case (wr.kind)
        WR_INC: begin
          if (cnt_q != CountMax) begin
            cnt_q <= cnt_q + COUNT_BITS'(1);
          end
        end
        WR_LOAD: begin
          page_q <= wr.page;
          cnt_q  <= COUNT_BITS'(1);
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

endmodule

/* sv/lfu_chk.sv */
`timescale 1ns / 1ps

module lfu_chk import lfu_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int EvLo = 1 + FRAME_IDX_W;

  // one reference at a time: input closes after a beat
  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input ready right after an accepted beat");

  // a hit evicts nothing
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |->
      (!m_axis_tdata[EvLo] && (m_axis_tdata[EvLo+EVICT_PAGE_W:EvLo+1] == '0)))
    else $error("eviction reported on a hit");

  // an eviction only on a fault
  a_evict_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[EvLo]) |-> m_axis_tdata[0])
    else $error("eviction without a fault");

  // a new result only comes out of a busy engine
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while engine idle");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

endmodule

bind lfu_page_replacement lfu_chk u_lfu_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
